@@ rtl/esw_pkg.sv @@
// Shared types, command and status codes for the event set unit.
// No dependencies; imported by every module in rtl/.
`default_nettype none
package esw_pkg;

  localparam int NUM_SETS = 8;
  localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  typedef enum logic [2:0] {
    CMD_WAIT    = 3'd0,
    CMD_RAISE   = 3'd1,
    CMD_DISABLE = 3'd2,
    CMD_ENABLE  = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_SET   = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_SET_BASE       = 1'b0,
    REG_ALLOCATED_SETS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] pending;
    logic [31:0] enable;
    logic [31:0] waiting;
  } set_words_t;

  typedef struct packed {
    logic [1:0] status;
    logic       got_event;
    logic [4:0] got_event_number;
    logic       caller_blocked;
    logic       woken_valid;
    logic [5:0] woken_thread;
    logic [4:0] woken_event;
  } result_t;

  // lowest set bit: {found, index}
  function automatic logic [5:0] lowest_bit(input logic [31:0] w);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 31; i >= 0; i--) begin
      if (w[i]) begin
        r = {1'b1, 5'(i)};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/esw_state_file.sv @@
// Per-set pending, enable and waiting words, one read and one write port.
// Depends on esw_pkg.
`default_nettype none
module esw_state_file
  import esw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [SET_W-1:0] rd_index,
  output set_words_t            rd_words,
  input  wire logic             wr_en,
  input  wire logic [SET_W-1:0] wr_index,
  input  set_words_t            wr_words
);

  set_words_t words [NUM_SETS];

  assign rd_words = words[rd_index];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_SETS; k++) begin
        words[k] <= '0;
      end
    end else if (wr_en) begin
      words[wr_index] <= wr_words;
    end
  end

endmodule
`default_nettype wire

@@ rtl/esw_cmd_logic.sv @@
// Argument checks and the read-modify-write of one set for one request.
// Depends on esw_pkg (codes, structs, lowest_bit).
`default_nettype none
module esw_cmd_logic
  import esw_pkg::*;
(
  input  wire logic [2:0]       command,
  input  wire logic [7:0]       object_id,
  input  wire logic [5:0]       event_number,
  input  wire logic [5:0]       thread_id,
  input  wire logic [7:0]       set_base,
  input  wire logic [7:0]       allocated_sets,
  output logic [SET_W-1:0]      set_index,
  input  set_words_t            words,
  output set_words_t            words_next,
  output logic                  write,
  output result_t               result
);

  logic [8:0]  diff;
  logic [31:0] ev_bit;
  logic [5:0]  low_ready;
  logic [5:0]  low_wait;
  logic [5:0]  th_m1;
  logic        in_set;

  assign diff      = {1'b0, object_id} - {1'b0, set_base};
  assign set_index = diff[SET_W-1:0];
  assign in_set    = !diff[8] && (diff[7:0] < 8'(NUM_SETS));
  assign ev_bit    = 32'd1 << event_number[4:0];
  assign low_ready = lowest_bit(words.pending & words.enable);
  assign low_wait  = lowest_bit(words.waiting);
  assign th_m1     = thread_id - 6'd1;

  always_comb begin
    result     = '0;
    words_next = words;
    write      = 1'b0;
    if (command <= CMD_CLEAR) begin
      if (event_number > 6'd31) begin
        result.status = ST_RANGE;
      end else if (!in_set) begin
        result.status = ST_NOT_SET;
      end else if (diff[7:0] >= 8'd8 || !allocated_sets[diff[2:0]]) begin
        result.status = ST_NOT_ALLOC;
      end else begin
        write = 1'b1;
        case (cmd_t'(command))
          CMD_WAIT: begin
            if (low_ready[5]) begin
              words_next.pending[low_ready[4:0]] = 1'b0;
              result.got_event        = 1'b1;
              result.got_event_number = low_ready[4:0];
            end else begin
              result.caller_blocked = 1'b1;
              if (thread_id >= 6'd1 && thread_id <= 6'd32) begin
                words_next.waiting[th_m1[4:0]] = 1'b1;
              end
            end
          end
          CMD_RAISE: begin
            if ((words.enable & ev_bit) == '0 || !low_wait[5]) begin
              words_next.pending = words.pending | ev_bit;
            end else begin
              words_next.waiting[low_wait[4:0]] = 1'b0;
              result.woken_valid  = 1'b1;
              result.woken_thread = {1'b0, low_wait[4:0]} + 6'd1;
              result.woken_event  = event_number[4:0];
            end
          end
          CMD_DISABLE: begin
            words_next.enable = words.enable & ~ev_bit;
          end
          CMD_ENABLE: begin
            if ((words.enable & ev_bit) == '0) begin
              words_next.enable = words.enable | ev_bit;
              if ((words.pending & ev_bit) != '0 && low_wait[5]) begin
                words_next.waiting[low_wait[4:0]] = 1'b0;
                words_next.pending = words.pending & ~ev_bit;
                result.woken_valid  = 1'b1;
                result.woken_thread = {1'b0, low_wait[4:0]} + 6'd1;
                result.woken_event  = event_number[4:0];
              end
            end
          end
          CMD_CLEAR: begin
            words_next.pending = words.pending & ~ev_bit;
          end
          default: begin
            write = 1'b0;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/event_set_wait_raise_unit.sv @@
// Top level: request register, set state, command logic, result register.
// Depends on esw_pkg, esw_state_file, esw_cmd_logic.
//
//   channel   direction  handshake             payload
//   request   in         req_valid/req_ready   command object_id event_number thread_id
//   result    out        rsp_valid/rsp_ready   status got_event ... woken_event
//   config    in         cfg_we                cfg_index cfg_data
//
// A request is registered, then processed against the set's words when the result
// register is free; the state write and the result register load happen on the same edge.
// One request per cycle sustained while the result side does not stall.
// Reset clears all set words, set_base to 0 and allocated_sets to all ones.
// A stalled result holds the registered request, and req_ready drops.
`default_nettype none
module event_set_wait_raise_unit
  import esw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire logic [2:0] command,
  input  wire logic [7:0] object_id,
  input  wire logic [5:0] event_number,
  input  wire logic [5:0] thread_id,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output logic [1:0]      status,
  output logic            got_event,
  output logic [4:0]      got_event_number,
  output logic            caller_blocked,
  output logic            woken_valid,
  output logic [5:0]      woken_thread,
  output logic [4:0]      woken_event,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] set_base;
  logic [7:0] allocated_sets;

  logic       s1_valid;
  logic [2:0] s1_command;
  logic [7:0] s1_object_id;
  logic [5:0] s1_event_number;
  logic [5:0] s1_thread_id;
  logic       advance;

  logic [SET_W-1:0] set_index;
  set_words_t       words;
  set_words_t       words_next;
  logic             write;
  result_t          result;
  result_t          rsp;

  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_base       <= 8'd0;
      allocated_sets <= 8'hFF;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SET_BASE:       set_base       <= cfg_data;
        REG_ALLOCATED_SETS: allocated_sets <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_command      <= command;
      s1_object_id    <= object_id;
      s1_event_number <= event_number;
      s1_thread_id    <= thread_id;
    end
  end

  esw_cmd_logic u_cmd (
    .command        (s1_command),
    .object_id      (s1_object_id),
    .event_number   (s1_event_number),
    .thread_id      (s1_thread_id),
    .set_base       (set_base),
    .allocated_sets (allocated_sets),
    .set_index      (set_index),
    .words          (words),
    .words_next     (words_next),
    .write          (write),
    .result         (result)
  );

  esw_state_file u_state (
    .clk      (clk),
    .rst      (rst),
    .rd_index (set_index),
    .rd_words (words),
    .wr_en    (advance && write),
    .wr_index (set_index),
    .wr_words (words_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

  assign status           = rsp.status;
  assign got_event        = rsp.got_event;
  assign got_event_number = rsp.got_event_number;
  assign caller_blocked   = rsp.caller_blocked;
  assign woken_valid      = rsp.woken_valid;
  assign woken_thread     = rsp.woken_thread;
  assign woken_event      = rsp.woken_event;

endmodule
`default_nettype wire

@@ dv/esw_scoreboard_pkg.sv @@
// Scoreboard for the event set unit: tracks set words and register state per request.
// Depends on esw_pkg for codes, register indexes and the result layout.
package esw_tb_pkg;
  import esw_pkg::*;

  class event_flag_scoreboard;
    logic [31:0] pending_w [NUM_SETS];
    logic [31:0] enable_w [NUM_SETS];
    logic [31:0] waiting_w [NUM_SETS];
    int          set_base;
    logic [7:0]  allocated;
    result_t     due_results [$];
    int          errors;

    function new();
      for (int k = 0; k < NUM_SETS; k++) begin
        pending_w[k] = '0;
        enable_w[k]  = '0;
        waiting_w[k] = '0;
      end
      set_base  = 0;
      allocated = 8'hFF;
      errors    = 0;
    endfunction

    function void configure(reg_idx_t idx, logic [7:0] value);
      if (idx == REG_SET_BASE) begin
        set_base = int'(value);
      end else begin
        allocated = value;
      end
    endfunction

    // 32 when no bit is set
    function int first_one(logic [31:0] w);
      for (int i = 0; i < 32; i++) begin
        if (w[i]) return i;
      end
      return 32;
    endfunction

    function result_t predict_command(logic [2:0] cmd, logic [7:0] obj, logic [5:0] ev,
                                      logic [5:0] th);
      result_t r;
      int      slot;
      int      j;
      r = '0;
      slot = int'(obj) - set_base;
      if (cmd <= CMD_CLEAR) begin
        if (ev > 6'd31) begin
          r.status = ST_RANGE;
        end else if (int'(obj) < set_base || slot >= NUM_SETS) begin
          r.status = ST_NOT_SET;
        end else if (slot >= 8 || !allocated[slot]) begin
          r.status = ST_NOT_ALLOC;
        end
        if (r.status == ST_OK) begin
          case (cmd)
            CMD_WAIT: begin
              j = first_one(pending_w[slot] & enable_w[slot]);
              if (j < 32) begin
                pending_w[slot][j] = 1'b0;
                r.got_event = 1'b1;
                r.got_event_number = 5'(j);
              end else begin
                r.caller_blocked = 1'b1;
                if (th >= 6'd1 && th <= 6'd32) waiting_w[slot][th - 6'd1] = 1'b1;
              end
            end
            CMD_RAISE: begin
              j = first_one(waiting_w[slot]);
              if (!enable_w[slot][ev] || j == 32) begin
                pending_w[slot][ev] = 1'b1;
              end else begin
                waiting_w[slot][j] = 1'b0;
                r.woken_valid = 1'b1;
                r.woken_thread = 6'(j + 1);
                r.woken_event = ev[4:0];
              end
            end
            CMD_DISABLE: begin
              enable_w[slot][ev] = 1'b0;
            end
            CMD_ENABLE: begin
              if (!enable_w[slot][ev]) begin
                enable_w[slot][ev] = 1'b1;
                if (pending_w[slot][ev]) begin
                  j = first_one(waiting_w[slot]);
                  if (j < 32) begin
                    waiting_w[slot][j] = 1'b0;
                    pending_w[slot][ev] = 1'b0;
                    r.woken_valid = 1'b1;
                    r.woken_thread = 6'(j + 1);
                    r.woken_event = ev[4:0];
                  end
                end
              end
            end
            default: begin
              pending_w[slot][ev] = 1'b0;
            end
          endcase
        end
      end
      return r;
    endfunction

    function void note_request(logic [2:0] cmd, logic [7:0] obj, logic [5:0] ev,
                               logic [5:0] th);
      due_results.push_back(predict_command(cmd, obj, ev, th));
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("got_event", want.got_event, got.got_event);
      compare_field("got_event_number", want.got_event_number, got.got_event_number);
      compare_field("caller_blocked", want.caller_blocked, got.caller_blocked);
      compare_field("woken_valid", want.woken_valid, got.woken_valid);
      compare_field("woken_thread", want.woken_thread, got.woken_thread);
      compare_field("woken_event", want.woken_event, got.woken_event);
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction
  endclass

endpackage

@@ dv/event_set_wait_raise_unit_tb.sv @@
// Testbench for event_set_wait_raise_unit: directed and random requests across
// several register settings, with random stalls on both channels.
// Depends on esw_pkg and esw_tb_pkg (dv/esw_scoreboard_pkg.sv).
module event_set_wait_raise_unit_tb;
  import esw_pkg::*;
  import esw_tb_pkg::*;

  localparam logic [2:0] CMD_BAD_LO  = 3'd5;
  localparam logic [2:0] CMD_BAD_MID = 3'd6;
  localparam logic [2:0] CMD_BAD_HI  = 3'd7;

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_ready;
  logic [2:0] command;
  logic [7:0] object_id;
  logic [5:0] event_number;
  logic [5:0] thread_id;
  logic       rsp_valid;
  logic       rsp_ready;
  logic [1:0] status;
  logic       got_event;
  logic [4:0] got_event_number;
  logic       caller_blocked;
  logic       woken_valid;
  logic [5:0] woken_thread;
  logic [4:0] woken_event;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [7:0] cfg_data;

  event_flag_scoreboard sb;
  bit                   hold_go;

  event_set_wait_raise_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .command(command), .object_id(object_id),
    .event_number(event_number), .thread_id(thread_id),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .status(status), .got_event(got_event), .got_event_number(got_event_number),
    .caller_blocked(caller_blocked), .woken_valid(woken_valid),
    .woken_thread(woken_thread), .woken_event(woken_event),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL event_set_wait_raise_unit");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) begin
      sb.note_request(command, object_id, event_number, thread_id);
    end
    if (!rst && rsp_valid && rsp_ready) begin
      sb.check_result({status, got_event, got_event_number, caller_blocked,
                       woken_valid, woken_thread, woken_event});
    end
  end

  // result side: stall patterns, plus one long hold-off to back up the request path
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int tick;
    bit held;
    rsp_ready <= 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_go && !held) begin
        held = 1'b1;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        case (mode)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= 1'($urandom_range(0, 1));
          2: rsp_ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ready <= (tick % 5 != 0);
        endcase
      end
    end
  end

  task automatic send_request(input logic [2:0] c, input logic [7:0] obj,
                              input logic [5:0] ev, input logic [5:0] th);
    req_valid <= 1'b1;
    command <= c;
    object_id <= obj;
    event_number <= ev;
    thread_id <= th;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic send_random();
    int          pick;
    logic [2:0]  c;
    logic [7:0]  obj;
    logic [5:0]  ev;
    logic [5:0]  th;
    pick = $urandom_range(0, 99);
    if (pick < 25) c = CMD_WAIT;
    else if (pick < 50) c = CMD_RAISE;
    else if (pick < 68) c = CMD_ENABLE;
    else if (pick < 78) c = CMD_DISABLE;
    else if (pick < 92) c = CMD_CLEAR;
    else if (pick < 96) c = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
    else c = 3'($urandom_range(CMD_WAIT, CMD_CLEAR));
    pick = $urandom_range(0, 99);
    if (pick < 88) obj = 8'(sb.set_base + $urandom_range(0, NUM_SETS - 1));
    else obj = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 65) ev = 6'($urandom_range(0, 7));
    else if (pick < 93) ev = 6'($urandom_range(0, 31));
    else ev = 6'($urandom_range(32, 63));
    pick = $urandom_range(0, 99);
    if (pick < 55) th = 6'($urandom_range(1, 8));
    else if (pick < 93) th = 6'($urandom_range(1, 32));
    else if (pick < 96) th = 6'd0;
    else th = 6'($urandom_range(33, 63));
    send_request(c, obj, ev, th);
  endtask

  task automatic random_phase(input int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      while (burst > 0 && sent < count) begin
        send_random();
        sent++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic program_sets(input logic [7:0] base, input logic [7:0] alloc);
    cfg_we <= 1'b1;
    cfg_index <= REG_SET_BASE;
    cfg_data <= base;
    @(posedge clk);
    sb.configure(REG_SET_BASE, base);
    cfg_index <= REG_ALLOCATED_SETS;
    cfg_data <= alloc;
    @(posedge clk);
    sb.configure(REG_ALLOCATED_SETS, alloc);
    cfg_we <= 1'b0;
  endtask

  task automatic directed_requests();
    send_request(CMD_WAIT, 8'd0, 6'd0, 6'd1);
    send_request(CMD_RAISE, 8'd0, 6'd5, 6'd0);
    send_request(CMD_ENABLE, 8'd0, 6'd5, 6'd0);
    send_request(CMD_RAISE, 8'd0, 6'd5, 6'd0);
    send_request(CMD_ENABLE, 8'd0, 6'd5, 6'd0);
    send_request(CMD_WAIT, 8'd0, 6'd0, 6'd2);
    send_request(CMD_WAIT, 8'd0, 6'd0, 6'd32);
    send_request(CMD_RAISE, 8'd0, 6'd31, 6'd0);
    send_request(CMD_ENABLE, 8'd0, 6'd31, 6'd0);
    send_request(CMD_WAIT, 8'd0, 6'd0, 6'd0);
    send_request(CMD_WAIT, 8'd0, 6'd0, 6'd63);
    send_request(CMD_ENABLE, 8'd0, 6'd0, 6'd0);
    send_request(CMD_RAISE, 8'd0, 6'd0, 6'd0);
    send_request(CMD_DISABLE, 8'd0, 6'd0, 6'd0);
    send_request(CMD_WAIT, 8'd0, 6'd0, 6'd3);
    send_request(CMD_RAISE, 8'd0, 6'd0, 6'd0);
    send_request(CMD_CLEAR, 8'd0, 6'd0, 6'd0);
    send_request(CMD_ENABLE, 8'd0, 6'd0, 6'd0);
    send_request(CMD_RAISE, 8'd0, 6'd0, 6'd0);
    send_request(CMD_RAISE, 8'd7, 6'd63, 6'd63);
    // range error wins over a bad object number
    send_request(CMD_WAIT, 8'd255, 6'd32, 6'd1);
    send_request(CMD_CLEAR, 8'd8, 6'd31, 6'd1);
    send_request(CMD_DISABLE, 8'd255, 6'd0, 6'd1);
    send_request(CMD_BAD_LO, 8'd255, 6'd63, 6'd63);
    send_request(CMD_BAD_MID, 8'd0, 6'd0, 6'd0);
    send_request(CMD_BAD_HI, 8'd0, 6'd0, 6'd0);
  endtask

  initial begin
    sb = new();
    hold_go = 1'b0;
    rst <= 1'b1;
    req_valid <= 1'b0;
    command <= CMD_WAIT;
    object_id <= '0;
    event_number <= '0;
    thread_id <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_SET_BASE;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    program_sets(8'd0, 8'hFF);
    directed_requests();
    hold_go = 1'b1;
    random_phase(300);
    drain();
    program_sets(8'd16, 8'hA5);
    random_phase(250);
    drain();
    program_sets(8'd255, 8'hFF);
    random_phase(150);
    drain();
    program_sets(8'd0, 8'h00);
    random_phase(100);
    drain();
    program_sets(8'd200, 8'h7E);
    random_phase(200);
    drain();
    program_sets(8'd0, 8'hFF);
    random_phase(200);
    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS event_set_wait_raise_unit");
    end else begin
      $display("FAIL event_set_wait_raise_unit");
    end
    $finish;
  end

endmodule
